FILE: hdl/lsp_pkg.sv
`default_nettype none
package lsp_pkg;

  localparam int POS_W      = 17;
  localparam int FRAME_IN_W = 16;
  localparam int DELAY_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_REWIND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_CHANNELS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS  = 3'd5;

  typedef struct packed {
    logic             ch;
    logic             playing;
    logic [POS_W-1:0] pos;
    logic             last;
  } lsp_meta_t;

endpackage
`default_nettype wire

FILE: hdl/lsp_store.sv
`default_nettype none
module lsp_store #(
  parameter int DEPTH  = 131072,
  parameter int ADDR_W = 17,
  parameter int DATA_W = 24
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // read-first: a read at the same edge as a write returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lsp_outq.sv
`default_nettype none
module lsp_outq #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             push,
  input  wire lsp_pkg::lsp_meta_t               push_meta,
  input  wire logic [SAMPLE_BITS-1:0]           push_sample,
  output logic                                  head_valid,
  input  wire logic                             pop_ready,
  output lsp_pkg::lsp_meta_t                    head_meta,
  output logic [SAMPLE_BITS-1:0]                head_sample,
  output logic [lsp_pkg::OUTQ_CNT_W-1:0]        count
);

  lsp_pkg::lsp_meta_t             meta_q   [lsp_pkg::OUTQ_DEPTH];
  logic [SAMPLE_BITS-1:0]         sample_q [lsp_pkg::OUTQ_DEPTH];
  logic [lsp_pkg::OUTQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [lsp_pkg::OUTQ_CNT_W-1:0] cnt_r;
  logic                           pop;

  assign pop         = head_valid && pop_ready;
  assign head_valid  = (cnt_r != '0);
  assign head_meta   = meta_q[rd_ptr_r];
  assign head_sample = sample_q[rd_ptr_r];
  assign count       = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      meta_q[wr_ptr_r]   <= push_meta;
      sample_q[wr_ptr_r] <= push_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/looping_sample_playback_core.sv
// pipeline: an accepted tick is registered in the issue stage; each result then
//   passes the store read in the read stage into the output queue; issue stalls
//   when the queue lacks room; one result per output channel (one or two) per tick
// reset: synchronous, active low; clears position, delay, edge history, registers
//   and the output queue; the sample store is not cleared
`default_nettype none
module looping_sample_playback_core #(
  parameter int FRAME_DEPTH  = 65536,
  parameter int MAX_CHANNELS = 2,
  parameter int SAMPLE_BITS  = 24
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       cfg_we,
  input  wire logic [lsp_pkg::CFG_IDX_W-1:0]              cfg_addr,
  input  wire logic [lsp_pkg::CFG_DATA_W-1:0]             cfg_wdata,
  input  wire logic                                       in_tvalid,
  output logic                                            in_tready,
  // active, seek_valid, seek_pos, load_frame, load_channel, load_sample
  input  wire logic [((36 + SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,
  // cmd
  input  wire logic                                       in_tuser,
  output logic                                            out_tvalid,
  input  wire logic                                       out_tready,
  // sample_out, playing, position
  output logic [((18 + SAMPLE_BITS + 7) / 8) * 8-1:0]     out_tdata,
  // out_channel
  output logic                                            out_tuser,
  output logic                                            out_tlast
);

  localparam int POS_W       = lsp_pkg::POS_W;
  localparam int DELAY_W     = lsp_pkg::DELAY_W;
  localparam int OUT_TDATA_W = ((18 + SAMPLE_BITS + 7) / 8) * 8;
  localparam int STORE_DEPTH = FRAME_DEPTH * MAX_CHANNELS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // input fields
  logic                               f_active, f_seek_valid, f_load_channel;
  logic [POS_W-1:0]                   f_seek_pos;
  logic [lsp_pkg::FRAME_IN_W-1:0]     f_load_frame;
  logic [SAMPLE_BITS-1:0]             f_load_sample;

  assign f_active       = in_tdata[0];
  assign f_seek_valid   = in_tdata[1];
  assign f_seek_pos     = in_tdata[18:2];
  assign f_load_frame   = in_tdata[34:19];
  assign f_load_channel = in_tdata[35];
  assign f_load_sample  = in_tdata[36 + SAMPLE_BITS - 1:36];

  // configuration
  logic               loop_enable_r, auto_rewind_r;
  logic [DELAY_W-1:0] loop_delay_r;
  logic [POS_W-1:0]   file_length_r;
  logic [1:0]         file_channels_r, out_channels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_enable_r   <= 1'b0;
      auto_rewind_r   <= 1'b0;
      loop_delay_r    <= '0;
      file_length_r   <= '0;
      file_channels_r <= 2'd0;
      out_channels_r  <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_addr)
        lsp_pkg::CFG_LOOP_ENABLE:   loop_enable_r   <= cfg_wdata[0];
        lsp_pkg::CFG_AUTO_REWIND:   auto_rewind_r   <= cfg_wdata[0];
        lsp_pkg::CFG_LOOP_DELAY:    loop_delay_r    <= cfg_wdata[DELAY_W-1:0];
        lsp_pkg::CFG_FILE_LENGTH:   file_length_r   <= cfg_wdata[POS_W-1:0];
        lsp_pkg::CFG_FILE_CHANNELS: file_channels_r <= cfg_wdata[1:0];
        lsp_pkg::CFG_OUT_CHANNELS:  out_channels_r  <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  // playback state
  logic [POS_W-1:0]   read_pos_r, rp_a, rp_nxt, frame_c, len_c;
  logic [DELAY_W-1:0] delay_left_r, dl_a, dl_nxt;
  logic               prev_active_r, from_c, past_end;

  // issue stage: one issue per output channel; the store is read only while playing
  logic               iss_valid_r, iss_ch_r, iss_two_r, iss_src1_r, iss_from_r;
  logic [POS_W-1:0]   iss_frame_r, iss_pos_r;
  logic               iss_last, iss_fire, room;

  // read stage
  logic               s1_valid_r;
  lsp_pkg::lsp_meta_t s1_meta_r;

  logic                          in_acc, tick_acc, load_we;
  logic [ADDR_W-1:0]             wr_addr, rd_addr;
  logic [SAMPLE_BITS-1:0]        rd_data, push_sample, head_sample;
  lsp_pkg::lsp_meta_t            head_meta;
  logic [lsp_pkg::OUTQ_CNT_W-1:0] q_cnt;

  assign len_c = (32'(file_length_r) > 32'(FRAME_DEPTH)) ? POS_W'(FRAME_DEPTH)
                                                         : file_length_r;

  always_comb begin
    rp_a = read_pos_r;
    dl_a = delay_left_r;
    if (f_seek_valid) begin
      rp_a = f_seek_pos;
      dl_a = '0;
    end
    if (f_active && !prev_active_r && auto_rewind_r) begin
      rp_a = '0;
      dl_a = '0;
    end
    past_end = (rp_a >= len_c);
    frame_c  = past_end ? '0 : rp_a;
    rp_nxt   = rp_a;
    dl_nxt   = dl_a;
    from_c   = 1'b0;
    if (f_active && file_channels_r != 2'd0 && len_c != '0) begin
      if (dl_a != '0) begin
        dl_nxt = dl_a - 1'b1;
      end else if (past_end && !loop_enable_r) begin
        rp_nxt = rp_a;
      end else if (past_end && loop_delay_r != '0) begin
        rp_nxt = '0;
        dl_nxt = loop_delay_r - 1'b1;
      end else begin
        from_c = 1'b1;
        rp_nxt = frame_c + 1'b1;
      end
    end
  end

  assign iss_last  = !iss_two_r || iss_ch_r;
  assign room      = ({1'b0, q_cnt} + {{lsp_pkg::OUTQ_CNT_W{1'b0}}, s1_valid_r})
                     < (lsp_pkg::OUTQ_CNT_W + 1)'(lsp_pkg::OUTQ_DEPTH);
  assign iss_fire  = iss_valid_r && room;
  assign in_tready = !iss_valid_r || (iss_fire && iss_last);
  assign in_acc    = in_tvalid && in_tready;
  assign tick_acc  = in_acc && (in_tuser == lsp_pkg::CMD_TICK);
  assign load_we   = in_acc && (in_tuser == lsp_pkg::CMD_LOAD)
                     && (32'(f_load_frame) < 32'(FRAME_DEPTH))
                     && (32'(f_load_channel) < 32'(MAX_CHANNELS));

  assign wr_addr = ADDR_W'(ADDR_W'(f_load_frame) * ADDR_W'(MAX_CHANNELS))
                   + ADDR_W'(f_load_channel);
  assign rd_addr = ADDR_W'(ADDR_W'(iss_frame_r) * ADDR_W'(MAX_CHANNELS))
                   + ADDR_W'(iss_ch_r & iss_src1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_pos_r    <= '0;
      delay_left_r  <= '0;
      prev_active_r <= 1'b0;
      iss_valid_r   <= 1'b0;
      iss_ch_r      <= 1'b0;
      s1_valid_r    <= 1'b0;
    end else begin
      if (tick_acc) begin
        read_pos_r    <= rp_nxt;
        delay_left_r  <= dl_nxt;
        prev_active_r <= f_active;
      end
      if (tick_acc) begin
        iss_valid_r <= 1'b1;
        iss_ch_r    <= 1'b0;
      end else if (iss_fire) begin
        iss_valid_r <= !iss_last;
        iss_ch_r    <= 1'b1;
      end
      s1_valid_r <= iss_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      iss_two_r   <= out_channels_r[1];
      iss_src1_r  <= (MAX_CHANNELS > 1) && file_channels_r[1];
      iss_from_r  <= from_c;
      iss_frame_r <= frame_c;
      iss_pos_r   <= rp_nxt;
    end
    if (iss_fire) begin
      s1_meta_r.ch      <= iss_ch_r;
      s1_meta_r.playing <= iss_from_r;
      s1_meta_r.pos     <= iss_pos_r;
      s1_meta_r.last    <= iss_last;
    end
  end

  lsp_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (wr_addr),
    .wr_data (f_load_sample),
    .rd_en   (iss_fire && iss_from_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign push_sample = s1_meta_r.playing ? rd_data : '0;

  lsp_outq #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (s1_valid_r),
    .push_meta   (s1_meta_r),
    .push_sample (push_sample),
    .head_valid  (out_tvalid),
    .pop_ready   (out_tready),
    .head_meta   (head_meta),
    .head_sample (head_sample),
    .count       (q_cnt)
  );

  assign out_tdata = OUT_TDATA_W'({head_meta.pos, head_meta.playing, head_sample});
  assign out_tuser = head_meta.ch;
  assign out_tlast = head_meta.last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= lsp_pkg::OUTQ_CNT_W'(lsp_pkg::OUTQ_DEPTH))
    else $error("output queue overflow");

  a_second_channel_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    (iss_fire && iss_ch_r) |-> iss_two_r)
    else $error("second channel issued for a single-channel tick");

  a_issue_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    iss_fire |=> s1_valid_r)
    else $error("issued read did not reach the read stage");

  a_accept_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!iss_valid_r || (iss_fire && iss_last)))
    else $error("transaction accepted while issue stage busy");

endmodule
`default_nettype wire
